// ===== sv/buddy_page_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Buddy page allocator assertion macros
// Concurrent checks clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define BPA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BPA_ASSERT_IMP(lbl, ante, cons, msg)
`define BPA_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== sv/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Sizes, codes, descriptor layout and sequencer states.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int DESC_DEPTH  = 256;
    localparam int DESC_AW     = $clog2(DESC_DEPTH);
    localparam int LINK_W      = DESC_AW + 1;
    localparam int ORDER_LIMIT = 10;
    localparam int PAGE_BITS   = 20;
    localparam int ORDER_W     = 4;
    localparam int CLASS_W     = 2;
    localparam int COUNT_W     = PAGE_BITS + 1;
    localparam int CFG_IDX_W   = 3;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(DESC_DEPTH);

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_INIT  = 2'd2,
        REQ_NOP   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_BAD_ORDER  = 3'd1,
        STS_NO_BLOCK   = 3'd2,
        STS_NOT_FOUND  = 3'd3,
        STS_TABLE_FULL = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        DS_INVALID = 2'd0,
        DS_FREE    = 2'd1,
        DS_USED    = 2'd2
    } dstat_t;

    localparam logic [CLASS_W-1:0] CLS_ANY    = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_KERNEL = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_USER   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ORDER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ORDER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KRES      = 3'd4;

    typedef struct packed {
        logic [PAGE_BITS-1:0] start;
        logic [ORDER_W-1:0]   order;
        logic [CLASS_W-1:0]   cls;
        dstat_t               stat;
        logic [LINK_W-1:0]    next;
    } desc_t;

    localparam int DESC_W = $bits(desc_t);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT_FILL,
        ST_AL_HEAD,
        ST_AL_CHK,
        ST_AL_POP,
        ST_AL_SPLIT,
        ST_AL_FIN,
        ST_FR_FIND,
        ST_FR_MCHK,
        ST_FR_BUDDY,
        ST_FR_WALK,
        ST_FR_WALKRD,
        ST_FR_MERGE,
        ST_FR_FIN,
        ST_DONE
    } state_t;

    function automatic logic [COUNT_W-1:0] pow2(input logic [ORDER_W-1:0] ord);
        pow2 = COUNT_W'(1) << ord;
    endfunction

endpackage

// ===== sv/bpa_ram.sv =====
// ----------------------------------------------------------------------------
// Buddy page allocator generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rd_reg <= mem_reg[raddr];
    end

    assign rdata = rd_reg;

endmodule

// ===== sv/buddy_page_allocator.sv =====
// No-op, bad order and bad init go straight to the result; init fills the whole table.
// Alloc climbs the order lists from the requested order past empty ones and heads of the
// wrong class, then splits down; free scans the table for the block, then per buddy order
// tried scans for the buddy, walks its list to unlink it and merges, one RAM read per cycle.
// One request at a time; the next beat is taken once the result is registered.
// Reset (aresetn low, synchronous): lists empty, table unused until init, counters zero.
// ----------------------------------------------------------------------------
// Buddy page allocator
// Descriptor RAM and spare stack RAM driven by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
`include "buddy_page_allocator_assert.svh"

module buddy_page_allocator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [bpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bpa_pkg::PAGE_BITS-1:0] cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,  // alloc_order, alloc_class, free_page
    input  logic [1:0]                    s_tuser,  // req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,  // page, free count, used count
    output logic [2:0]                    m_tuser   // status
);

    localparam int AW = bpa_pkg::DESC_AW;
    localparam int LW = bpa_pkg::LINK_W;
    localparam int PB = bpa_pkg::PAGE_BITS;
    localparam int OW = bpa_pkg::ORDER_W;
    localparam int CW = bpa_pkg::COUNT_W;

    // configuration
    logic [PB-1:0] cfg_base_reg, cfg_total_reg, cfg_kres_reg;
    logic [OW-1:0] cfg_min_reg, cfg_max_reg;

    // sequencer state
    bpa_pkg::state_t  st_reg, st_next;
    logic             init_done_reg, init_done_next;
    logic [LW-1:0]    head_reg [bpa_pkg::ORDER_LIMIT+1];
    logic [LW-1:0]    head_next [bpa_pkg::ORDER_LIMIT+1];
    logic [LW-1:0]    spare_cnt_reg, spare_cnt_next;
    logic [OW-1:0]    top_reg, top_next;
    logic [CW-1:0]    free_reg, free_next;
    logic [PB-1:0]    lat_base_reg, lat_base_next, lat_total_reg, lat_total_next;
    logic [PB-1:0]    lat_kres_reg, lat_kres_next;
    logic [OW-1:0]    lat_min_reg, lat_min_next;

    logic [OW-1:0]    i_reg, i_next, ord_reg, ord_next;
    logic [1:0]       cls_reg, cls_next;
    logic [AW-1:0]    d_reg, d_next, b_reg, b_next, idx_reg, idx_next;
    bpa_pkg::desc_t   dword_reg, dword_next, bword_reg, bword_next;
    bpa_pkg::desc_t   pword_reg, pword_next;
    logic [PB-1:0]    page_reg, page_next, bpage_reg, bpage_next;
    logic [LW-1:0]    cnt_reg, cnt_next, steps_reg, steps_next;
    logic [LW-1:0]    cur_reg, cur_next, prev_reg, prev_next;
    logic             pend_reg, pend_next;
    bpa_pkg::status_t res_sts_reg, res_sts_next;
    logic [PB-1:0]    res_page_reg, res_page_next;

    // result register
    logic             m_valid_reg, m_valid_next;
    logic [2:0]       m_sts_reg, m_sts_next;
    logic [PB-1:0]    m_page_reg, m_page_next, m_free_reg, m_free_next;
    logic [PB-1:0]    m_used_reg, m_used_next;

    // RAM ports
    logic             d_we;
    logic [AW-1:0]    d_waddr, d_raddr;
    bpa_pkg::desc_t   d_wdata, d_rdata;
    logic             s_we;
    logic [AW-1:0]    s_waddr, s_raddr, s_rdata;
    logic [AW-1:0]    s_wdata;

    bpa_ram #(.WIDTH(bpa_pkg::DESC_W), .DEPTH(bpa_pkg::DESC_DEPTH)) u_desc_ram (
        .aclk  (aclk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    bpa_ram #(.WIDTH(AW), .DEPTH(bpa_pkg::DESC_DEPTH)) u_spare_ram (
        .aclk  (aclk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    logic              in_beat;
    bpa_pkg::req_t     in_req;
    logic [OW-1:0]     in_order, fit_ord;
    logic [1:0]        in_cls;
    logic [PB-1:0]     in_page;
    logic              kern, skip, match_used, match_bud;
    logic [CW-1:0]     kern_lim;
    logic [LW-1:0]     sp_dec, h;
    logic [CW-1:0]     spare_need;

    assign s_tready = (st_reg == bpa_pkg::ST_IDLE);
    assign in_beat  = s_tvalid && s_tready;
    assign in_req   = bpa_pkg::req_t'(s_tuser);
    assign in_order = s_tdata[3:0];
    assign in_cls   = s_tdata[5:4];
    assign in_page  = s_tdata[25:6];

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_sts_reg;
    assign m_tdata  = {4'd0, m_used_reg, m_free_reg, m_page_reg};

    assign sp_dec   = spare_cnt_reg - LW'(1);
    assign kern_lim = {1'b0, lat_base_reg} + {1'b0, lat_kres_reg};
    assign kern     = (lat_kres_reg != '0) && ({1'b0, d_rdata.start} < kern_lim);
    assign skip     = ((cls_reg == bpa_pkg::CLS_KERNEL) && !kern) ||
                      ((cls_reg == bpa_pkg::CLS_USER) && kern);
    assign spare_need = CW'(i_reg) - CW'(ord_reg);
    assign match_used = (d_rdata.stat == bpa_pkg::DS_USED) &&
                        (d_rdata.start == page_reg);
    assign match_bud  = (idx_reg != d_reg) && (d_rdata.stat == bpa_pkg::DS_FREE) &&
                        (d_rdata.start == bpage_reg) && (d_rdata.order == ord_reg);
    assign h = head_reg[i_reg];

    always_comb begin
        fit_ord = '0;
        for (int k = 0; k <= bpa_pkg::ORDER_LIMIT; k++) begin
            if ((OW'(k) <= cfg_max_reg) && (CW'(1) << k) <= {1'b0, cfg_total_reg}) begin
                fit_ord = OW'(k);
            end
        end
    end

    always_comb begin
        st_next        = st_reg;
        init_done_next = init_done_reg;
        head_next      = head_reg;
        spare_cnt_next = spare_cnt_reg;
        top_next       = top_reg;
        free_next      = free_reg;
        lat_base_next  = lat_base_reg;
        lat_total_next = lat_total_reg;
        lat_kres_next  = lat_kres_reg;
        lat_min_next   = lat_min_reg;
        i_next         = i_reg;
        ord_next       = ord_reg;
        cls_next       = cls_reg;
        d_next         = d_reg;
        b_next         = b_reg;
        idx_next       = idx_reg;
        dword_next     = dword_reg;
        bword_next     = bword_reg;
        pword_next     = pword_reg;
        page_next      = page_reg;
        bpage_next     = bpage_reg;
        cnt_next       = cnt_reg;
        steps_next     = steps_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        pend_next      = pend_reg;
        res_sts_next   = res_sts_reg;
        res_page_next  = res_page_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_sts_next     = m_sts_reg;
        m_page_next    = m_page_reg;
        m_free_next    = m_free_reg;
        m_used_next    = m_used_reg;
        d_we           = 1'b0;
        d_waddr        = d_reg;
        d_wdata        = dword_reg;
        d_raddr        = cnt_reg[AW-1:0];
        s_we           = 1'b0;
        s_waddr        = spare_cnt_reg[AW-1:0];
        s_wdata        = b_reg;
        s_raddr        = sp_dec[AW-1:0];

        case (st_reg)
            bpa_pkg::ST_IDLE: begin
                if (in_beat) begin
                    res_sts_next  = bpa_pkg::STS_OK;
                    res_page_next = '0;
                    st_next       = bpa_pkg::ST_DONE;
                    case (in_req)
                        bpa_pkg::REQ_ALLOC: begin
                            ord_next = in_order;
                            cls_next = in_cls;
                            i_next   = in_order;
                            if (in_order < lat_min_reg || in_order > top_reg) begin
                                res_sts_next = bpa_pkg::STS_BAD_ORDER;
                            end else begin
                                st_next = bpa_pkg::ST_AL_HEAD;
                            end
                        end
                        bpa_pkg::REQ_FREE: begin
                            page_next = in_page;
                            cnt_next  = '0;
                            pend_next = 1'b0;
                            if (init_done_reg) begin
                                st_next = bpa_pkg::ST_FR_FIND;
                            end else begin
                                res_sts_next = bpa_pkg::STS_NOT_FOUND;
                            end
                        end
                        bpa_pkg::REQ_INIT: begin
                            if (cfg_max_reg > OW'(bpa_pkg::ORDER_LIMIT) ||
                                cfg_min_reg > cfg_max_reg || cfg_total_reg == '0) begin
                                res_sts_next = bpa_pkg::STS_BAD_ORDER;
                            end else begin
                                for (int k = 0; k <= bpa_pkg::ORDER_LIMIT; k++) begin
                                    head_next[k] = bpa_pkg::NULL_LINK;
                                end
                                head_next[fit_ord] = '0;
                                init_done_next   = 1'b1;
                                spare_cnt_next   = LW'(bpa_pkg::DESC_DEPTH - 1);
                                top_next         = fit_ord;
                                free_next        = bpa_pkg::pow2(fit_ord);
                                lat_base_next    = cfg_base_reg;
                                lat_total_next   = cfg_total_reg;
                                lat_min_next     = cfg_min_reg;
                                lat_kres_next    = cfg_kres_reg;
                                d_we             = 1'b1;
                                d_waddr          = '0;
                                d_wdata          = '{start: cfg_base_reg, order: fit_ord,
                                                     cls: bpa_pkg::CLS_ANY,
                                                     stat: bpa_pkg::DS_FREE,
                                                     next: bpa_pkg::NULL_LINK};
                                cnt_next         = '0;
                                st_next          = bpa_pkg::ST_INIT_FILL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            bpa_pkg::ST_INIT_FILL: begin
                s_we     = 1'b1;
                s_waddr  = cnt_reg[AW-1:0];
                s_wdata  = AW'(bpa_pkg::DESC_DEPTH - 1) - cnt_reg[AW-1:0];
                d_we     = 1'b1;
                d_waddr  = cnt_reg[AW-1:0] + AW'(1);
                d_wdata  = '{start: '0, order: '0, cls: bpa_pkg::CLS_ANY,
                             stat: bpa_pkg::DS_INVALID, next: bpa_pkg::NULL_LINK};
                cnt_next = cnt_reg + LW'(1);
                if (cnt_reg == LW'(bpa_pkg::DESC_DEPTH - 2)) begin
                    st_next = bpa_pkg::ST_DONE;
                end
            end

            bpa_pkg::ST_AL_HEAD: begin
                d_raddr = h[AW-1:0];
                if (i_reg > top_reg) begin
                    res_sts_next = bpa_pkg::STS_NO_BLOCK;
                    st_next      = bpa_pkg::ST_DONE;
                end else if (h[AW]) begin
                    i_next = i_reg + OW'(1);
                end else begin
                    d_next  = h[AW-1:0];
                    st_next = bpa_pkg::ST_AL_CHK;
                end
            end

            bpa_pkg::ST_AL_CHK: begin
                if (skip) begin
                    i_next  = i_reg + OW'(1);
                    st_next = bpa_pkg::ST_AL_HEAD;
                end else if ({{(CW-LW){1'b0}}, spare_cnt_reg} < spare_need) begin
                    res_sts_next = bpa_pkg::STS_TABLE_FULL;
                    st_next      = bpa_pkg::ST_DONE;
                end else begin
                    head_next[i_reg] = d_rdata.next;
                    dword_next       = d_rdata;
                    dword_next.cls   = cls_reg;
                    dword_next.stat  = bpa_pkg::DS_USED;
                    free_next        = free_reg - bpa_pkg::pow2(i_reg);
                    st_next = (i_reg > ord_reg) ? bpa_pkg::ST_AL_POP : bpa_pkg::ST_AL_FIN;
                end
            end

            bpa_pkg::ST_AL_POP: begin
                i_next         = i_reg - OW'(1);
                spare_cnt_next = sp_dec;
                st_next        = bpa_pkg::ST_AL_SPLIT;
            end

            bpa_pkg::ST_AL_SPLIT: begin
                d_we                = 1'b1;
                d_waddr             = s_rdata;
                d_wdata             = '{start: dword_reg.start + PB'(bpa_pkg::pow2(i_reg)),
                                        order: i_reg, cls: bpa_pkg::CLS_ANY,
                                        stat: bpa_pkg::DS_FREE,
                                        next: head_reg[i_reg]};
                head_next[i_reg]    = {1'b0, s_rdata};
                free_next           = free_reg + bpa_pkg::pow2(i_reg);
                st_next = (i_reg > ord_reg) ? bpa_pkg::ST_AL_POP : bpa_pkg::ST_AL_FIN;
            end

            bpa_pkg::ST_AL_FIN: begin
                d_we          = 1'b1;
                d_wdata       = dword_reg;
                d_wdata.order = ord_reg;
                res_page_next = dword_reg.start;
                st_next       = bpa_pkg::ST_DONE;
            end

            bpa_pkg::ST_FR_FIND, bpa_pkg::ST_FR_BUDDY: begin
                if (!cnt_reg[AW]) begin
                    cnt_next  = cnt_reg + LW'(1);
                    pend_next = 1'b1;
                    idx_next  = cnt_reg[AW-1:0];
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg) begin
                    if (st_reg == bpa_pkg::ST_FR_FIND) begin
                        if (match_used) begin
                            d_next             = idx_reg;
                            dword_next         = d_rdata;
                            ord_next           = d_rdata.order;
                            free_next          = free_reg + bpa_pkg::pow2(d_rdata.order);
                            st_next            = bpa_pkg::ST_FR_MCHK;
                        end else if (idx_reg == AW'(bpa_pkg::DESC_DEPTH - 1)) begin
                            res_sts_next = bpa_pkg::STS_NOT_FOUND;
                            st_next      = bpa_pkg::ST_DONE;
                        end
                    end else begin
                        if (match_bud) begin
                            b_next     = idx_reg;
                            bword_next = d_rdata;
                            cur_next   = head_reg[ord_reg];
                            prev_next  = bpa_pkg::NULL_LINK;
                            steps_next = '0;
                            st_next    = bpa_pkg::ST_FR_WALK;
                        end else if (idx_reg == AW'(bpa_pkg::DESC_DEPTH - 1)) begin
                            st_next = bpa_pkg::ST_FR_FIN;
                        end
                    end
                end
            end

            bpa_pkg::ST_FR_MCHK: begin
                bpage_next = page_reg ^ PB'(bpa_pkg::pow2(ord_reg));
                cnt_next   = '0;
                pend_next  = 1'b0;
                st_next = (ord_reg < top_reg) ? bpa_pkg::ST_FR_BUDDY : bpa_pkg::ST_FR_FIN;
            end

            bpa_pkg::ST_FR_WALK: begin
                d_raddr = cur_reg[AW-1:0];
                if (steps_reg == LW'(bpa_pkg::DESC_DEPTH) || cur_reg[AW]) begin
                    st_next = bpa_pkg::ST_FR_MERGE;
                end else if (cur_reg[AW-1:0] == b_reg) begin
                    if (prev_reg[AW]) begin
                        head_next[ord_reg] = bword_reg.next;
                    end else begin
                        d_we         = 1'b1;
                        d_waddr      = prev_reg[AW-1:0];
                        d_wdata      = pword_reg;
                        d_wdata.next = bword_reg.next;
                    end
                    st_next = bpa_pkg::ST_FR_MERGE;
                end else begin
                    st_next = bpa_pkg::ST_FR_WALKRD;
                end
            end

            bpa_pkg::ST_FR_WALKRD: begin
                prev_next  = cur_reg;
                pword_next = d_rdata;
                cur_next   = d_rdata.next;
                steps_next = steps_reg + LW'(1);
                st_next    = bpa_pkg::ST_FR_WALK;
            end

            bpa_pkg::ST_FR_MERGE: begin
                d_we = 1'b1;
                if (page_reg < bpage_reg) begin
                    d_waddr          = b_reg;
                    d_wdata          = bword_reg;
                    s_wdata          = b_reg;
                end else begin
                    d_waddr          = d_reg;
                    d_wdata          = dword_reg;
                    s_wdata          = d_reg;
                    d_next           = b_reg;
                    dword_next       = bword_reg;
                    page_next        = bpage_reg;
                end
                d_wdata.stat = bpa_pkg::DS_INVALID;
                if (spare_cnt_reg < LW'(bpa_pkg::DESC_DEPTH)) begin
                    s_we           = 1'b1;
                    spare_cnt_next = spare_cnt_reg + LW'(1);
                end
                ord_next = ord_reg + OW'(1);
                st_next  = bpa_pkg::ST_FR_MCHK;
            end

            bpa_pkg::ST_FR_FIN: begin
                d_we               = 1'b1;
                d_wdata            = dword_reg;
                d_wdata.order      = ord_reg;
                d_wdata.stat       = bpa_pkg::DS_FREE;
                d_wdata.next       = head_reg[ord_reg];
                head_next[ord_reg] = {1'b0, d_reg};
                st_next            = bpa_pkg::ST_DONE;
            end

            bpa_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_sts_next   = res_sts_reg;
                    m_page_next  = res_page_reg;
                    m_free_next  = free_reg[PB-1:0];
                    m_used_next  = lat_total_reg - free_reg[PB-1:0];
                    st_next      = bpa_pkg::ST_IDLE;
                end
            end

            default: begin
                st_next = bpa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= bpa_pkg::ST_IDLE;
            init_done_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            spare_cnt_reg <= '0;
            top_reg       <= '0;
            free_reg      <= '0;
            lat_base_reg  <= '0;
            lat_total_reg <= '0;
            lat_kres_reg  <= '0;
            lat_min_reg   <= '0;
            pend_reg      <= 1'b0;
            cfg_base_reg  <= '0;
            cfg_total_reg <= PB'(1024);
            cfg_min_reg   <= '0;
            cfg_max_reg   <= OW'(10);
            cfg_kres_reg  <= '0;
            for (int k = 0; k <= bpa_pkg::ORDER_LIMIT; k++) begin
                head_reg[k] <= bpa_pkg::NULL_LINK;
            end
        end else begin
            st_reg        <= st_next;
            init_done_reg <= init_done_next;
            m_valid_reg   <= m_valid_next;
            spare_cnt_reg <= spare_cnt_next;
            top_reg       <= top_next;
            free_reg      <= free_next;
            lat_base_reg  <= lat_base_next;
            lat_total_reg <= lat_total_next;
            lat_kres_reg  <= lat_kres_next;
            lat_min_reg   <= lat_min_next;
            pend_reg      <= pend_next;
            head_reg      <= head_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    bpa_pkg::CFG_BASE:      cfg_base_reg  <= cfg_wdata;
                    bpa_pkg::CFG_TOTAL:     cfg_total_reg <= cfg_wdata;
                    bpa_pkg::CFG_MIN_ORDER: cfg_min_reg   <= cfg_wdata[OW-1:0];
                    bpa_pkg::CFG_MAX_ORDER: cfg_max_reg   <= cfg_wdata[OW-1:0];
                    bpa_pkg::CFG_KRES:      cfg_kres_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        i_reg        <= i_next;
        ord_reg      <= ord_next;
        cls_reg      <= cls_next;
        d_reg        <= d_next;
        b_reg        <= b_next;
        idx_reg      <= idx_next;
        dword_reg    <= dword_next;
        bword_reg    <= bword_next;
        pword_reg    <= pword_next;
        page_reg     <= page_next;
        bpage_reg    <= bpage_next;
        cnt_reg      <= cnt_next;
        steps_reg    <= steps_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        res_sts_reg  <= res_sts_next;
        res_page_reg <= res_page_next;
        m_sts_reg    <= m_sts_next;
        m_page_reg   <= m_page_next;
        m_free_reg   <= m_free_next;
        m_used_reg   <= m_used_next;
    end

    `BPA_ASSERT_NXT(a_busy_after_beat, s_tvalid && s_tready, !s_tready, "input taken while busy")
    `BPA_ASSERT_IMP(a_spare_bound, 1'b1, spare_cnt_reg <= LW'(bpa_pkg::DESC_DEPTH), "spare overflow")
    `BPA_ASSERT_IMP(a_result_from_done, $rose(m_valid_reg), $past(st_reg) == bpa_pkg::ST_DONE, "stray result")

endmodule
